@@ design/sam_pkg.sv @@
// shared types and constants of the spatial atom match marker
`default_nettype none
package sam_pkg;

  // coordinate format
  localparam int unsigned COORD_W         = 32;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned ONE_FIXED       = 1 << COORD_FRAC_BITS;

  // tolerance registers
  localparam int unsigned TOL_W = 24;
  localparam logic [TOL_W-1:0] HEAVY_TOL_RST = TOL_W'((ONE_FIXED + 5000) / 10000);
  localparam logic [TOL_W-1:0] HYD_TOL_RST   = TOL_W'((ONE_FIXED + 5) / 10);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAVY_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HYD_TOL   = 1'b1;

  // item function codes
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_CLEAR = 2'd1;
  localparam logic [1:0] FN_MATCH = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_MATCH      = 3'd1;
  localparam logic [2:0] ST_H_TOL      = 3'd2;
  localparam logic [2:0] ST_HEAVY_MISS = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  // distance pipeline depth
  localparam int unsigned DIST_LAT = 5;
  localparam int unsigned DR_W     = $clog2(DIST_LAT);

  typedef struct packed {
    logic [1:0]                func;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      is_hydrogen;
    logic [7:0]                frag_tag;
  } sam_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] atom_index;
  } sam_out_t;

  // one stored molecule atom
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      hyd;
    logic [7:0]                mark;
  } sam_entry_t;

  // per-cell controls
  typedef struct packed {
    logic shift;
    logic ld_we;
    logic mk_we;
  } sam_cell_ctl_t;

endpackage
`default_nettype wire

@@ design/sam_cell.sv @@
// one ring cell holding a stored atom and its match tag
`default_nettype none
module sam_cell (
  input  wire                    clk,
  input  sam_pkg::sam_cell_ctl_t ctl,
  input  sam_pkg::sam_entry_t    nbr_in,
  input  sam_pkg::sam_entry_t    ld_ent,
  input  wire  [7:0]             tag,
  output sam_pkg::sam_entry_t    ent
);
  import sam_pkg::*;

  sam_entry_t ent_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ent_r <= nbr_in;
    end else if (ctl.ld_we) begin
      ent_r <= ld_ent;
    end else if (ctl.mk_we) begin
      ent_r.mark <= tag;
    end
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

@@ design/sam_dist.sv @@
// pipelined squared-distance test of one stored atom against the fragment atom
`default_nettype none
module sam_dist #(
  parameter int unsigned IDX_W = 8
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         en_valid,
  input  wire  [IDX_W-1:0]            en_idx,
  input  sam_pkg::sam_in_t            frag,
  input  sam_pkg::sam_entry_t         ent,
  input  wire  [sam_pkg::TOL_W-1:0]   heavy_tol,
  input  wire  [sam_pkg::TOL_W-1:0]   hyd_tol,
  output logic                        hit,
  output logic [IDX_W-1:0]            hit_idx
);
  import sam_pkg::*;

  localparam int unsigned DW = COORD_W + 1;
  localparam int unsigned SW = 2 * COORD_W;
  localparam int unsigned TW = 2 * TOL_W;

  // stage 1: exact differences
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  logic [TOL_W-1:0]     tol1_r;
  // stage 2: magnitudes
  logic [COORD_W-1:0]   ax_r, ay_r, az_r;
  logic [TOL_W-1:0]     tol2_r;
  // stage 3: squares
  logic [SW-1:0]        sx_r, sy_r, sz3_r;
  logic [TW-1:0]        tsq3_r;
  // stage 4: partial sum
  logic [SW:0]          sxy_r;
  logic [SW-1:0]        sz4_r;
  logic [TW-1:0]        tsq4_r;
  // stage 5: compare
  logic                 hit_r;
  logic [IDX_W-1:0]     idx_r [DIST_LAT];
  logic [DIST_LAT-2:0]  v_r;

  logic [DW-1:0] nx, ny, nz;
  logic [SW+1:0] d2;

  function automatic logic signed [DW-1:0] sx33(input logic signed [COORD_W-1:0] v);
    sx33 = {v[COORD_W-1], v};
  endfunction

  assign nx = -dx_r;
  assign ny = -dy_r;
  assign nz = -dz_r;
  // the squared tolerance stays far below the saturation point, so comparing the
  // exact sum gives the same answer as comparing the saturated one
  assign d2 = {1'b0, sxy_r} + {2'b0, sz4_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      hit_r <= 1'b0;
    end else begin
      v_r   <= {v_r[DIST_LAT-3:0], en_valid};
      hit_r <= v_r[DIST_LAT-2] && (d2 <= {{(SW+2-TW){1'b0}}, tsq4_r});
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= sx33(frag.pos_x) - sx33(ent.x);
    dy_r   <= sx33(frag.pos_y) - sx33(ent.y);
    dz_r   <= sx33(frag.pos_z) - sx33(ent.z);
    tol1_r <= (frag.is_hydrogen && ent.hyd) ? hyd_tol : heavy_tol;

    ax_r   <= dx_r[DW-1] ? nx[COORD_W-1:0] : dx_r[COORD_W-1:0];
    ay_r   <= dy_r[DW-1] ? ny[COORD_W-1:0] : dy_r[COORD_W-1:0];
    az_r   <= dz_r[DW-1] ? nz[COORD_W-1:0] : dz_r[COORD_W-1:0];
    tol2_r <= tol1_r;

    sx_r   <= ax_r * ax_r;
    sy_r   <= ay_r * ay_r;
    sz3_r  <= az_r * az_r;
    tsq3_r <= tol2_r * tol2_r;

    sxy_r  <= {1'b0, sx_r} + {1'b0, sy_r};
    sz4_r  <= sz3_r;
    tsq4_r <= tsq3_r;
  end

  always_ff @(posedge clk) begin
    idx_r[0] <= en_idx;
    for (int k = 1; k < DIST_LAT; k++) begin
      idx_r[k] <= idx_r[k-1];
    end
  end

  assign hit     = hit_r;
  assign hit_idx = idx_r[DIST_LAT-1];

endmodule
`default_nettype wire

@@ design/spatial_atom_match_marker_core.sv @@
// top level of the spatial atom match marker: atom ring, scan control, result
// load, clear and unused func: result strobe in the cycle after acceptance
// match: the ring rotates once through the distance pipe (S_SCAN, S_DRAIN, S_FINISH);
//   scan length set by the ring length; a new item can be taken from the result strobe
// results cannot be stalled: each result is shown on out_data for one cycle
// synchronous reset empties the table and loads the default tolerances
`default_nettype none
module spatial_atom_match_marker_core #(
  parameter int unsigned MAX_ATOMS = 256
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // item channel
  input  wire                            start,
  output logic                           busy,
  input  sam_pkg::sam_in_t               in_data,
  // result channel
  output logic                           out_valid,
  output sam_pkg::sam_out_t              out_data,
  // configuration channel
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [sam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [sam_pkg::TOL_W-1:0]      cfg_data
);
  import sam_pkg::*;

  localparam int unsigned IDX_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ATOMS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // control registers
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] atom_count_r, atom_count_nxt;
  logic [CNT_W-1:0] sc_cnt_r, sc_cnt_nxt;
  logic [DR_W-1:0]  dr_cnt_r, dr_cnt_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  // payload registers
  sam_in_t          cmd_r, cmd_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  sam_out_t         out_r, out_nxt;
  // configuration
  logic [TOL_W-1:0] heavy_tol_r, hyd_tol_r;

  // ring wiring: cell i takes cell i+1 when rotating, cell 0 is the scan head
  sam_entry_t       ent [MAX_ATOMS];
  sam_entry_t       ld_ent;
  logic             accept;
  logic             ld_go;
  logic             mk_go;
  logic             rotate;
  logic             full;
  logic             feed;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;

  assign accept = start && !busy;
  assign full   = (atom_count_r == CNT_W'(MAX_ATOMS));
  assign ld_go  = accept && (in_data.func == FN_LOAD) && !full;
  assign rotate = (state_r == S_SCAN);
  // tag goes on the first hit once the ring is back home
  assign mk_go  = (state_r == S_FINISH) && found_r;
  // only untagged, loaded entries are tested
  assign feed   = rotate && (sc_cnt_r < atom_count_r) && (ent[0].mark == 8'd0);

  assign ld_ent = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z,
                    hyd: in_data.is_hydrogen, mark: 8'd0};

  for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_cell
    sam_cell_ctl_t ctl;
    assign ctl.shift = rotate;
    assign ctl.ld_we = ld_go && (atom_count_r[IDX_W-1:0] == IDX_W'(i));
    assign ctl.mk_we = mk_go && (hit_idx_r == IDX_W'(i));
    sam_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .nbr_in (ent[(i + 1) % MAX_ATOMS]),
      .ld_ent (ld_ent),
      .tag    (cmd_r.frag_tag),
      .ent    (ent[i])
    );
  end

  // distance test of the entry at the scan head
  sam_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .en_valid  (feed),
    .en_idx    (sc_cnt_r[IDX_W-1:0]),
    .frag      (cmd_r),
    .ent       (ent[0]),
    .heavy_tol (heavy_tol_r),
    .hyd_tol   (hyd_tol_r),
    .hit       (hit),
    .hit_idx   (hit_idx)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    atom_count_nxt = atom_count_r;
    sc_cnt_nxt     = sc_cnt_r;
    dr_cnt_nxt     = dr_cnt_r;
    found_nxt      = found_r;
    out_valid_nxt  = 1'b0;
    cmd_nxt        = cmd_r;
    hit_idx_nxt    = hit_idx_r;
    out_nxt        = out_r;

    // hits leave the pipe in index order, keep the first one
    if ((state_r == S_SCAN || state_r == S_DRAIN) && hit && !found_r) begin
      found_nxt   = 1'b1;
      hit_idx_nxt = hit_idx;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_data;
          case (in_data.func)
            FN_LOAD: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt = '{status: ST_FULL, atom_index: 8'd0};
              end else begin
                out_nxt        = '{status: ST_DONE, atom_index: 8'(atom_count_r)};
                atom_count_nxt = atom_count_r + CNT_W'(1);
              end
            end
            FN_CLEAR: begin
              // entries above the count are never read, so only the count resets
              out_valid_nxt  = 1'b1;
              out_nxt        = '{status: ST_DONE, atom_index: 8'd0};
              atom_count_nxt = '0;
            end
            FN_MATCH: begin
              state_nxt  = S_SCAN;
              sc_cnt_nxt = '0;
              found_nxt  = 1'b0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: ST_DONE, atom_index: 8'd0};
            end
          endcase
        end
      end
      S_SCAN: begin
        // one full turn brings every entry back to its home cell
        sc_cnt_nxt = sc_cnt_r + CNT_W'(1);
        if (sc_cnt_r == CNT_W'(MAX_ATOMS - 1)) begin
          state_nxt  = S_DRAIN;
          dr_cnt_nxt = '0;
        end
      end
      S_DRAIN: begin
        // wait for the last entry to leave the distance pipe
        dr_cnt_nxt = dr_cnt_r + DR_W'(1);
        if (dr_cnt_r == DR_W'(DIST_LAT - 1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (found_r) begin
          out_nxt = '{status: ST_MATCH, atom_index: 8'(hit_idx_r)};
        end else if (cmd_r.is_hydrogen) begin
          out_nxt = '{status: ST_H_TOL, atom_index: 8'd0};
        end else begin
          out_nxt = '{status: ST_HEAVY_MISS, atom_index: 8'd0};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      atom_count_r <= '0;
      sc_cnt_r     <= '0;
      dr_cnt_r     <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      atom_count_r <= atom_count_nxt;
      sc_cnt_r     <= sc_cnt_nxt;
      dr_cnt_r     <= dr_cnt_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    hit_idx_r <= hit_idx_nxt;
    out_r     <= out_nxt;
  end

  // tolerance registers, always ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heavy_tol_r <= HEAVY_TOL_RST;
      hyd_tol_r   <= HYD_TOL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEAVY_TOL: heavy_tol_r <= cfg_data;
        REG_HYD_TOL:   hyd_tol_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ tb/sam_result_checker.sv @@
// result checker for the spatial atom match marker: predicts each answer and compares
`timescale 1ns / 100ps
module sam_result_checker #(
  parameter int unsigned MAX_ATOMS = 256
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire                           busy,
  input  sam_pkg::sam_in_t              in_data,
  input  wire                           out_valid,
  input  sam_pkg::sam_out_t             out_data,
  input  wire                           cfg_valid,
  input  wire                           cfg_ready,
  input  wire  [sam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [sam_pkg::TOL_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            outstanding,
  output int                            matches_seen,
  output int                            misses_seen,
  output int                            full_seen
);
  import sam_pkg::*;

  // own copy of the atom table
  logic signed [COORD_W-1:0] tab_x [MAX_ATOMS];
  logic signed [COORD_W-1:0] tab_y [MAX_ATOMS];
  logic signed [COORD_W-1:0] tab_z [MAX_ATOMS];
  logic                      tab_h [MAX_ATOMS];
  logic [7:0]                tag_of [MAX_ATOMS];
  int unsigned               filled;
  logic [TOL_W-1:0]          tol_heavy;
  logic [TOL_W-1:0]          tol_hyd;

  sam_out_t awaited_answers [$];

  function automatic logic [63:0] axis_sq(logic signed [COORD_W-1:0] a,
                                          logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic [COORD_W-1:0]      m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
    return {32'd0, m} * {32'd0, m};
  endfunction

  // squared distance, saturating at all ones
  function automatic logic [63:0] dist_sq(sam_in_t it, int unsigned i);
    logic [65:0] s;
    s = {2'b0, axis_sq(it.pos_x, tab_x[i])} + {2'b0, axis_sq(it.pos_y, tab_y[i])}
      + {2'b0, axis_sq(it.pos_z, tab_z[i])};
    return (s[65:64] != 2'b0) ? '1 : s[63:0];
  endfunction

  // apply one item to the table and return its answer
  function automatic sam_out_t predict_answer(sam_in_t it);
    sam_out_t         ans;
    logic [TOL_W-1:0] t;
    logic [63:0]      lim;
    bit               hit;
    int unsigned      i;
    ans.status     = ST_DONE;
    ans.atom_index = '0;
    hit            = 1'b0;
    case (it.func)
      FN_LOAD: begin
        if (filled >= MAX_ATOMS) begin
          ans.status = ST_FULL;
        end else begin
          tab_x[filled]  = it.pos_x;
          tab_y[filled]  = it.pos_y;
          tab_z[filled]  = it.pos_z;
          tab_h[filled]  = it.is_hydrogen;
          tag_of[filled] = '0;
          ans.atom_index = 8'(filled);
          filled++;
        end
      end
      FN_CLEAR: begin
        for (i = 0; i < MAX_ATOMS; i++) tag_of[i] = '0;
        filled = 0;
      end
      FN_MATCH: begin
        for (i = 0; i < filled && !hit; i++) begin
          if (tag_of[i] == '0) begin
            t   = (it.is_hydrogen && tab_h[i]) ? tol_hyd : tol_heavy;
            lim = {40'd0, t} * {40'd0, t};
            if (dist_sq(it, i) <= lim) begin
              tag_of[i]      = it.frag_tag;
              hit            = 1'b1;
              ans.status     = ST_MATCH;
              ans.atom_index = 8'(i);
            end
          end
        end
        if (!hit) ans.status = it.is_hydrogen ? ST_H_TOL : ST_HEAVY_MISS;
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    sam_out_t want;
    if (!rst_n) begin
      for (int unsigned k = 0; k < MAX_ATOMS; k++) tag_of[k] = '0;
      filled       = 0;
      tol_heavy    = HEAVY_TOL_RST;
      tol_hyd      = HYD_TOL_RST;
      fail_count   = 0;
      matches_seen = 0;
      misses_seen  = 0;
      full_seen    = 0;
      awaited_answers.delete();
    end else begin
      // results first: an item accepted at this edge cannot answer at it
      if (out_valid) begin
        if (awaited_answers.size() == 0) begin
          $display("%0t: unexpected result status %0d index %0d", $time,
                   out_data.status, out_data.atom_index);
          fail_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, out_data.status);
            fail_count++;
          end
          if (out_data.atom_index !== want.atom_index) begin
            $display("%0t: atom_index mismatch, expected %0d, actual %0d", $time,
                     want.atom_index, out_data.atom_index);
            fail_count++;
          end
          if (want.status == ST_MATCH) matches_seen++;
          if (want.status == ST_H_TOL || want.status == ST_HEAVY_MISS) misses_seen++;
          if (want.status == ST_FULL) full_seen++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HEAVY_TOL) tol_heavy = cfg_data;
        else if (cfg_index == REG_HYD_TOL) tol_hyd = cfg_data;
      end
      if (start && !busy) awaited_answers.push_back(predict_answer(in_data));
    end
    outstanding = awaited_answers.size();
  end

endmodule

@@ tb/spatial_atom_match_marker_core_test.sv @@
// stimulus and verdict for the spatial atom match marker core
`timescale 1ns / 100ps
module spatial_atom_match_marker_core_test;
  import sam_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ITEM_BUDGET = 1400;
  // function code the block leaves unused
  localparam logic [1:0]  FN_SPARE    = 2'd3;
  localparam logic [TOL_W-1:0] TOL_MAX = '1;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  sam_in_t               in_data;
  logic                  out_valid;
  sam_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [TOL_W-1:0]      cfg_data;

  int fail_count, outstanding, matches_seen, misses_seen, full_seen;

  // positions loaded since the last clear, used to aim match items at stored atoms
  logic signed [COORD_W-1:0] aim_x [TABLE_DEPTH];
  logic signed [COORD_W-1:0] aim_y [TABLE_DEPTH];
  logic signed [COORD_W-1:0] aim_z [TABLE_DEPTH];
  logic                      aim_h [TABLE_DEPTH];
  int unsigned               aim_n;

  // current cluster that loads are drawn from; negative spread means anywhere
  logic signed [COORD_W-1:0] clu_x, clu_y, clu_z;
  int                        clu_spread;

  logic [TOL_W-1:0] cur_heavy, cur_hyd;
  int unsigned      items_sent, tol_settings, episode;
  bit               steady;

  spatial_atom_match_marker_core #(
    .MAX_ATOMS (TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sam_result_checker #(
    .MAX_ATOMS (TABLE_DEPTH)
  ) answer_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .matches_seen (matches_seen),
    .misses_seen  (misses_seen),
    .full_seen    (full_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop: far beyond every item matching with the longest gaps
  initial begin
    #(40_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic sam_in_t mk(logic [1:0] fn, logic signed [COORD_W-1:0] x,
                                 logic signed [COORD_W-1:0] y,
                                 logic signed [COORD_W-1:0] z, logic h, logic [7:0] tag);
    sam_in_t it;
    it.func        = fn;
    it.pos_x       = x;
    it.pos_y       = y;
    it.pos_z       = z;
    it.is_hydrogen = h;
    it.frag_tag    = tag;
    return it;
  endfunction

  // coordinate near the cluster center, or anywhere
  function automatic logic signed [COORD_W-1:0] near(logic signed [COORD_W-1:0] c);
    if (clu_spread < 0) return $urandom;
    return c + (int'($urandom_range(0, 2 * clu_spread)) - clu_spread);
  endfunction

  function automatic logic [7:0] rand_tag();
    return ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  // called at a falling edge; holds start until the block takes the item,
  // then returns at a falling edge with start still high unless a gap was taken
  task automatic issue(input sam_in_t it);
    int unsigned r, gap;
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.func != FN_SPARE) items_sent++;
    if (it.func == FN_LOAD && aim_n < TABLE_DEPTH) begin
      aim_x[aim_n] = it.pos_x;
      aim_y[aim_n] = it.pos_y;
      aim_z[aim_n] = it.pos_z;
      aim_h[aim_n] = it.is_hydrogen;
      aim_n++;
    end else if (it.func == FN_CLEAR) begin
      aim_n = 0;
    end
    @(negedge clk);
    // mostly back to back, some short gaps, a few long ones
    r = $urandom_range(0, 99);
    if (steady || r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 16);
    else gap = $urandom_range(30, 80);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // drop start and wait until every answer is in, block idle
  task automatic drain();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write both tolerance registers, in random order, while the block is idle
  task automatic set_tolerances(input logic [TOL_W-1:0] heavy, input logic [TOL_W-1:0] hyd);
    logic [CFG_IDX_W-1:0] first, idx;
    first = $urandom_range(0, 1) ? REG_HYD_TOL : REG_HEAVY_TOL;
    for (int k = 0; k < 2; k++) begin
      idx = (k == 0) ? first : ((first == REG_HEAVY_TOL) ? REG_HYD_TOL : REG_HEAVY_TOL);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= (idx == REG_HEAVY_TOL) ? heavy : hyd;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    cur_heavy = heavy;
    cur_hyd   = hyd;
    tol_settings++;
  endtask

  task automatic load_in_cluster();
    issue(mk(FN_LOAD, near(clu_x), near(clu_y), near(clu_z), 1'($urandom_range(0, 1)),
             8'($urandom)));
  endtask

  // match item aimed at a stored atom: exact, well inside, on the boundary or just out
  task automatic aim_match();
    int unsigned      j, mode;
    logic             fh;
    logic [TOL_W-1:0] t;
    int               half, reach, axis;
    int               d [3];
    j  = $urandom_range(0, aim_n - 1);
    fh = $urandom_range(0, 1) ? aim_h[j] : 1'($urandom_range(0, 1));
    t  = (fh && aim_h[j]) ? cur_hyd : cur_heavy;
    d  = '{0, 0, 0};
    mode = $urandom_range(0, 3);
    if (mode == 1) begin
      half = int'(t) / 2;
      for (int k = 0; k < 3; k++) d[k] = int'($urandom_range(0, 2 * half)) - half;
    end else if (mode >= 2) begin
      reach = (mode == 2) ? int'(t) : int'(t) + 1;
      axis  = $urandom_range(0, 2);
      d[axis] = $urandom_range(0, 1) ? reach : -reach;
    end
    issue(mk(FN_MATCH, aim_x[j] + d[0], aim_y[j] + d[1], aim_z[j] + d[2], fh, rand_tag()));
  endtask

  initial begin
    int unsigned n_load, n_match, r, sel;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    aim_n      = 0;
    items_sent = 0;
    tol_settings = 0;
    episode    = 0;
    steady     = 1'b0;
    cur_heavy  = HEAVY_TOL_RST;
    cur_hyd    = HYD_TOL_RST;
    clu_x = 0; clu_y = 0; clu_z = 0; clu_spread = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part, reset tolerances (heavy 7, hydrogen 6554) ----
    // matches against an empty table: heavy fails, hydrogen is tolerated
    issue(mk(FN_MATCH, 0, 0, 0, 1'b0, 8'd1));
    issue(mk(FN_MATCH, 0, 0, 0, 1'b1, 8'd1));
    // four atoms: origin, a hydrogen, and the two coordinate corners
    issue(mk(FN_LOAD, 0, 0, 0, 1'b0, 8'd0));
    issue(mk(FN_LOAD, 1000, -1000, 0, 1'b1, 8'd0));
    issue(mk(FN_LOAD, C_MAX, C_MAX, C_MAX, 1'b0, 8'd0));
    issue(mk(FN_LOAD, C_MIN, C_MIN, C_MIN, 1'b1, 8'd0));
    // distance exactly the heavy tolerance still matches
    issue(mk(FN_MATCH, 7, 0, 0, 1'b0, 8'd255));
    // heavy fragment next to a stored hydrogen uses the heavy tolerance: miss
    issue(mk(FN_MATCH, 1008, -1000, 0, 1'b0, 8'd2));
    // hydrogen pair on the boundary with tag zero: entry stays free
    issue(mk(FN_MATCH, 1000 + 6554, -1000, 0, 1'b1, 8'd0));
    issue(mk(FN_MATCH, 1000 + 6555, -1000, 0, 1'b1, 8'd3));
    issue(mk(FN_MATCH, 1000, -997, 0, 1'b1, 8'd5));
    // opposite corner saturates the distance, then the lower corner matches
    issue(mk(FN_MATCH, C_MIN, C_MIN, C_MIN, 1'b0, 8'd9));
    // hydrogen fragment against a heavy atom uses the heavy tolerance
    issue(mk(FN_MATCH, C_MAX - 6, C_MAX, C_MAX, 1'b1, 8'd17));
    // unused function code, both field extremes
    issue(mk(FN_SPARE, 0, 0, 0, 1'b0, 8'd0));
    issue(mk(FN_SPARE, -1, -1, -1, 1'b1, 8'd255));
    // everything tagged now
    issue(mk(FN_MATCH, 0, 0, 0, 1'b0, 8'd4));
    issue(mk(FN_CLEAR, -1, -1, -1, 1'b1, 8'd255));
    issue(mk(FN_MATCH, 0, 0, 0, 1'b0, 8'd4));
    issue(mk(FN_LOAD, C_MAX, C_MAX, C_MAX, 1'b1, 8'd255));
    issue(mk(FN_MATCH, C_MAX, C_MAX, C_MAX, 1'b1, 8'd0));
    // zero tolerances: only an exact hit matches
    drain();
    set_tolerances('0, '0);
    issue(mk(FN_MATCH, C_MAX, C_MAX, C_MAX, 1'b1, 8'd0));
    issue(mk(FN_MATCH, C_MAX - 1, C_MAX, C_MAX, 1'b1, 8'd3));
    // widest tolerances
    drain();
    set_tolerances(TOL_MAX, TOL_MAX);
    issue(mk(FN_LOAD, C_MIN, C_MIN, C_MIN, 1'b0, 8'd0));
    issue(mk(FN_MATCH, C_MIN + COORD_W'(TOL_MAX), C_MIN, C_MIN, 1'b0, 8'd6));
    issue(mk(FN_MATCH, C_MAX, C_MAX, C_MAX, 1'b0, 8'd1));

    // ---- random part: episodes of clear, load a cluster, match into it ----
    while (items_sent < ITEM_BUDGET) begin
      episode++;
      steady = ($urandom_range(0, 4) == 0);
      // new tolerance setting every few episodes, only with the block idle
      if (episode % 5 == 0) begin
        drain();
        sel = $urandom_range(0, 5);
        case (sel)
          0: set_tolerances(HEAVY_TOL_RST, HYD_TOL_RST);
          1: set_tolerances('0, '0);
          2: set_tolerances(TOL_MAX, TOL_MAX);
          3: set_tolerances(TOL_W'($urandom_range(0, 4095)), TOL_W'($urandom_range(0, 4095)));
          4: set_tolerances(TOL_W'($urandom_range(0, 1 << 20)),
                            TOL_W'($urandom_range(0, 1 << 20)));
          default: set_tolerances(TOL_W'($urandom), TOL_W'($urandom));
        endcase
      end
      if (aim_n == TABLE_DEPTH || $urandom_range(0, 3) != 0)
        issue(mk(FN_CLEAR, $urandom, $urandom, $urandom, 1'($urandom), 8'($urandom)));

      // cluster shape: one point, tight, loose, wide, or anywhere
      clu_x = $urandom;
      clu_y = $urandom;
      clu_z = $urandom;
      case ($urandom_range(0, 4))
        0: clu_spread = 0;
        1: clu_spread = 16;
        2: clu_spread = 4096;
        3: clu_spread = 1 << 20;
        default: clu_spread = -1;
      endcase

      // first episode fills the table past its end; a few later ones do too
      r = $urandom_range(0, 99);
      if (episode == 1 || r >= 97) n_load = TABLE_DEPTH - aim_n + $urandom_range(1, 3);
      else if (r < 70) n_load = $urandom_range(1, 8);
      else n_load = $urandom_range(9, 40);
      for (int unsigned k = 0; k < n_load; k++) load_in_cluster();

      n_match = $urandom_range(1, (n_load < 13) ? 2 * n_load + 4 : 30);
      for (int unsigned k = 0; k < n_match; k++) begin
        r = $urandom_range(0, 99);
        if (r < 72 && aim_n > 0)
          aim_match();
        else if (r < 85)
          issue(mk(FN_MATCH, $urandom, $urandom, $urandom, 1'($urandom), 8'($urandom)));
        else if (r < 92)
          load_in_cluster();
        else if (r < 97)
          issue(mk(FN_SPARE, $urandom, $urandom, $urandom, 1'($urandom), 8'($urandom)));
        else
          issue(mk(2'($urandom), $urandom, $urandom, $urandom, 1'($urandom), 8'($urandom)));
      end
    end

    // wind down: every answer in, then a quiet wait before the verdict
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d items over %0d tolerance settings", items_sent, tol_settings);
    $display("answers: %0d matched, %0d unmatched, %0d table full",
             matches_seen, misses_seen, full_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
